[design/imu_complementary_attitude_macros.svh]
// Assertion macros for the IMU complementary attitude estimator.
// Included by the top level; needs nothing else.
`ifndef IMU_COMPLEMENTARY_ATTITUDE_MACROS_SVH
`define IMU_COMPLEMENTARY_ATTITUDE_MACROS_SVH
`ifndef ASSERT_OFF
`define IMUCA_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define IMUCA_ASSERT_NORST(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define IMUCA_ASSERT(lbl, clk, rst, prop, msg)
`define IMUCA_ASSERT_NORST(lbl, clk, prop, msg)
`endif
`endif

[design/imuca_pkg.sv]
// Shared types and constants for the IMU complementary attitude estimator.
// Used by the controller, the datapath and the top level; depends on nothing.
package imuca_pkg;

   localparam logic [31:0] CALIB_END_RST    = 32'd1000000;
   localparam logic [15:0] BIAS_WEIGHT_RST  = 16'd33554;
   localparam logic [15:0] STEP_TIME_RST    = 16'd33554;
   localparam logic [15:0] BLEND_WEIGHT_RST = 16'd655;
   localparam logic [15:0] INV_GRAVITY_RST  = 16'd6681;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CALIB_END    = 3'd0,
      CSR_BIAS_WEIGHT  = 3'd1,
      CSR_STEP_TIME    = 3'd2,
      CSR_BLEND_WEIGHT = 3'd3,
      CSR_INV_GRAVITY  = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [31:0] calib_end_time;
      logic [15:0] bias_weight;
      logic [15:0] step_time;
      logic [15:0] blend_weight;
      logic [15:0] inv_gravity;
   } cfg_type;

   // Operand pair fed to the shared multiplier.
   typedef enum logic [3:0] {
      MUL_NONE,
      MUL_GX_BW,
      MUL_GY_BW,
      MUL_GZ_BW,
      MUL_AY_IG,
      MUL_AXN_IG,
      MUL_PROD_W,
      MUL_RX_DT,
      MUL_RY_DT,
      MUL_RZ_DT,
      MUL_PX_W1,
      MUL_PY_W1
   } mul_sel_type;

   // What the datapath does with the last product or the state this cycle.
   typedef enum logic [3:0] {
      WB_NONE,
      WB_BIAS_X,
      WB_BIAS_Y,
      WB_BIAS_Z,
      WB_RATES,
      WB_AW_Y,
      WB_AW_X,
      WB_PRED_X,
      WB_PRED_Y,
      WB_YAW,
      WB_ROLL,
      WB_PITCH
   } wb_sel_type;

   typedef struct packed {
      logic        load;
      mul_sel_type mul;
      wb_sel_type  wb;
   } dp_cmd_type;

   typedef struct packed {
      logic calib;
   } dp_status_type;

endpackage

[design/imuca_ctrl.sv]
// Sequencer for the IMU complementary attitude estimator.
// Issues at most one multiply and one write-back command per cycle, none while held by rsp_stall; uses imuca_pkg.
module imuca_ctrl
   import imuca_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   localparam int STEP_W = 4;
   localparam logic [STEP_W-1:0] STEP_OUT  = 4'd10;
   localparam logic [STEP_W-1:0] STEP_LAST = 4'd12;

   state_type         state_ff;
   logic [STEP_W-1:0] step_ff;
   logic              rsp_valid_ff;
   logic              hold;

   // A write back is issued at the step after the multiply that feeds it; the product waits in prod_ff.
   function automatic dp_cmd_type step_cmd(input logic [STEP_W-1:0] step, input logic calib);
      dp_cmd_type c;
      c = '{load: 1'b0, mul: MUL_NONE, wb: WB_NONE};
      unique case (step)
         4'd0:  c.mul = MUL_GX_BW;
         4'd1:  begin c.mul = MUL_GY_BW;  c.wb = calib ? WB_BIAS_X : WB_NONE; end
         4'd2:  begin c.mul = MUL_GZ_BW;  c.wb = calib ? WB_BIAS_Y : WB_NONE; end
         4'd3:  begin c.mul = MUL_AY_IG;  c.wb = calib ? WB_BIAS_Z : WB_NONE; end
         4'd4:  begin c.mul = MUL_PROD_W; c.wb = WB_RATES; end
         4'd5:  begin c.mul = MUL_AXN_IG; c.wb = WB_AW_Y; end
         4'd6:  c.mul = MUL_PROD_W;
         4'd7:  begin c.mul = MUL_RX_DT;  c.wb = WB_AW_X; end
         4'd8:  begin c.mul = MUL_RY_DT;  c.wb = WB_PRED_X; end
         4'd9:  begin c.mul = MUL_RZ_DT;  c.wb = WB_PRED_Y; end
         4'd10: begin c.mul = MUL_PX_W1;  c.wb = WB_YAW; end
         4'd11: begin c.mul = MUL_PY_W1;  c.wb = WB_ROLL; end
         4'd12: c.wb = WB_PITCH;
         default: c.wb = WB_NONE;
      endcase
      return c;
   endfunction

   // The result registers are first written at STEP_OUT, so the sequence
   // waits there while the previous item is still held by the receiver.
   assign hold = (step_ff == STEP_OUT) && rsp_valid_ff && rsp_stall;

   always_comb begin
      cmd = '{load: 1'b0, mul: MUL_NONE, wb: WB_NONE};
      if (state_ff == ST_IDLE) begin
         cmd.load = req_valid;
      end else if (!hold) begin
         cmd = step_cmd(step_ff, status.calib);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= ST_RUN;
                  step_ff  <= '0;
               end
            end
            ST_RUN: begin
               if (!hold) begin
                  if (step_ff == STEP_LAST) begin
                     state_ff     <= ST_IDLE;
                     rsp_valid_ff <= 1'b1;
                  end else begin
                     step_ff <= step_ff + 1'b1;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

[design/imuca_dp.sv]
// Datapath of the IMU complementary attitude estimator: one shared
// 34x18 signed multiplier, bias and angle state, result registers. Uses imuca_pkg.
module imuca_dp
   import imuca_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  cfg_type             cfg,
   input  dp_cmd_type          cmd,
   output dp_status_type       status,
   input  logic [31:0]         req_sample_time,
   input  logic signed [15:0]  req_gyro_x,
   input  logic signed [15:0]  req_gyro_y,
   input  logic signed [15:0]  req_gyro_z,
   input  logic signed [15:0]  req_accel_x,
   input  logic signed [15:0]  req_accel_y,
   input  logic                req_pitch_reset,
   output logic signed [31:0]  rsp_roll_angle,
   output logic signed [31:0]  rsp_pitch_angle,
   output logic signed [31:0]  rsp_yaw_angle
);

   localparam int MUL_A_W = 34;
   localparam int MUL_B_W = 18;
   localparam int PROD_W  = 52;
   localparam int ACCW_W  = 49;
   localparam int SUM_W   = 54;

   localparam logic signed [PROD_W-1:0] HALF_Q10 = PROD_W'(1) << 9;
   localparam logic signed [PROD_W-1:0] HALF_Q21 = PROD_W'(1) << 20;
   localparam logic signed [SUM_W-1:0]  HALF_Q16 = SUM_W'(1) << 15;
   localparam logic signed [SUM_W-1:0]  SAT_MAX  = {{(SUM_W-31){1'b0}}, {31{1'b1}}};
   localparam logic signed [SUM_W-1:0]  SAT_MIN  = {{(SUM_W-31){1'b1}}, 31'b0};

   function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
      logic signed [31:0] r;
      if (v > SAT_MAX) begin
         r = SAT_MAX[31:0];
      end else if (v < SAT_MIN) begin
         r = SAT_MIN[31:0];
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   logic signed [15:0] gx_ff, gy_ff, gz_ff, ax_ff, ay_ff;
   logic               rst_ff;
   logic               calib_ff;

   logic signed [31:0] bias_x_ff, bias_y_ff, bias_z_ff;
   logic signed [31:0] roll_ff, pitch_ff, yaw_ff;
   logic signed [MUL_A_W-1:0] rate_x_ff, rate_y_ff, rate_z_ff;
   logic signed [MUL_A_W-1:0] pred_x_ff, pred_y_ff;
   logic signed [ACCW_W-1:0]  aw_x_ff, aw_y_ff;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [31:0] rsp_roll_ff, rsp_pitch_ff, rsp_yaw_ff;

   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [PROD_W-1:0]  prod_in;
   logic signed [MUL_B_W-1:0] bw_b, dt_b, ig_b, w_b, w1_b;

   logic signed [31:0]        bias_cur;
   logic signed [PROD_W-1:0]  bias_rnd, bias_shr;
   logic signed [31:0]        bias_in;
   logic signed [PROD_W-1:0]  term_rnd, term_shr;
   logic signed [31:0]        est_sel;
   logic signed [MUL_A_W-1:0] pred_in;
   logic signed [31:0]        yaw_in;
   logic signed [ACCW_W-1:0]  aw_sel;
   logic signed [SUM_W-1:0]   blend_sum, blend_rnd, blend_shr;
   logic signed [31:0]        blend_in;

   assign bw_b = {2'b00, cfg.bias_weight};
   assign dt_b = {2'b00, cfg.step_time};
   assign ig_b = {2'b00, cfg.inv_gravity};
   assign w_b  = {2'b00, cfg.blend_weight};
   // Weight on the prediction, 65536 - w, always in 1 .. 65536.
   assign w1_b = {1'b0, 17'h10000 - {1'b0, cfg.blend_weight}};

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.mul)
         MUL_GX_BW:  begin mul_a = MUL_A_W'(gx_ff);  mul_b = bw_b; end
         MUL_GY_BW:  begin mul_a = MUL_A_W'(gy_ff);  mul_b = bw_b; end
         MUL_GZ_BW:  begin mul_a = MUL_A_W'(gz_ff);  mul_b = bw_b; end
         MUL_AY_IG:  begin mul_a = MUL_A_W'(ay_ff);  mul_b = ig_b; end
         MUL_AXN_IG: begin mul_a = -MUL_A_W'(ax_ff); mul_b = ig_b; end
         // Second factor of accel * (1/g) * w; the first product fits 34 bits.
         MUL_PROD_W: begin mul_a = prod_ff[MUL_A_W-1:0]; mul_b = w_b; end
         MUL_RX_DT:  begin mul_a = rate_x_ff; mul_b = dt_b; end
         MUL_RY_DT:  begin mul_a = rate_y_ff; mul_b = dt_b; end
         MUL_RZ_DT:  begin mul_a = rate_z_ff; mul_b = dt_b; end
         MUL_PX_W1:  begin mul_a = pred_x_ff; mul_b = w1_b; end
         MUL_PY_W1:  begin mul_a = pred_y_ff; mul_b = w1_b; end
         default:    begin mul_a = '0; mul_b = '0; end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   // Bias update: round the Q34 increment to Q24 and add with saturation.
   always_comb begin
      case (cmd.wb)
         WB_BIAS_X: bias_cur = bias_x_ff;
         WB_BIAS_Y: bias_cur = bias_y_ff;
         default:   bias_cur = bias_z_ff;
      endcase
   end
   assign bias_rnd = prod_ff + HALF_Q10;
   assign bias_shr = bias_rnd >>> 10;
   assign bias_in  = sat32(SUM_W'(bias_cur) + SUM_W'(bias_shr));

   // Integration term: Q48 rounded to Q27.
   assign term_rnd = prod_ff + HALF_Q21;
   assign term_shr = term_rnd >>> 21;
   assign est_sel  = (cmd.wb == WB_PRED_X) ? roll_ff : pitch_ff;
   assign pred_in  = MUL_A_W'(est_sel) + MUL_A_W'(term_shr);
   assign yaw_in   = sat32(SUM_W'(yaw_ff) + SUM_W'(term_shr));

   // Blend: prediction part and accel part are both Q43 before one rounding.
   assign aw_sel    = (cmd.wb == WB_ROLL) ? aw_y_ff : aw_x_ff;
   assign blend_sum = SUM_W'(prod_ff) + (SUM_W'(aw_sel) <<< 2);
   assign blend_rnd = blend_sum + HALF_Q16;
   assign blend_shr = blend_rnd >>> 16;
   assign blend_in  = sat32(blend_shr);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         gx_ff    <= req_gyro_x;
         gy_ff    <= req_gyro_y;
         gz_ff    <= req_gyro_z;
         ax_ff    <= req_accel_x;
         ay_ff    <= req_accel_y;
         rst_ff   <= req_pitch_reset;
         calib_ff <= (req_sample_time < cfg.calib_end_time);
      end
      if (cmd.mul != MUL_NONE) begin
         prod_ff <= prod_in;
      end
      case (cmd.wb)
         WB_RATES: begin
            rate_x_ff <= {{4{gx_ff[15]}}, gx_ff, 14'b0} - {{2{bias_x_ff[31]}}, bias_x_ff};
            rate_y_ff <= {{4{gy_ff[15]}}, gy_ff, 14'b0} - {{2{bias_y_ff[31]}}, bias_y_ff};
            rate_z_ff <= {{4{gz_ff[15]}}, gz_ff, 14'b0} - {{2{bias_z_ff[31]}}, bias_z_ff};
         end
         WB_AW_Y:   aw_y_ff      <= prod_ff[ACCW_W-1:0];
         WB_AW_X:   aw_x_ff      <= prod_ff[ACCW_W-1:0];
         WB_PRED_X: pred_x_ff    <= pred_in;
         WB_PRED_Y: pred_y_ff    <= pred_in;
         WB_YAW:    rsp_yaw_ff   <= yaw_in;
         WB_ROLL:   rsp_roll_ff  <= blend_in;
         WB_PITCH:  rsp_pitch_ff <= blend_in;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bias_x_ff <= '0;
         bias_y_ff <= '0;
         bias_z_ff <= '0;
         roll_ff   <= '0;
         pitch_ff  <= '0;
         yaw_ff    <= '0;
      end else begin
         case (cmd.wb)
            WB_BIAS_X: bias_x_ff <= bias_in;
            WB_BIAS_Y: bias_y_ff <= bias_in;
            WB_BIAS_Z: bias_z_ff <= bias_in;
            WB_YAW:    yaw_ff    <= yaw_in;
            WB_ROLL:   roll_ff   <= blend_in;
            // The item's result keeps the new pitch; only the state is cleared.
            WB_PITCH:  pitch_ff  <= rst_ff ? 32'sd0 : blend_in;
            default: ;
         endcase
      end
   end

   assign status.calib    = calib_ff;
   assign rsp_roll_angle  = rsp_roll_ff;
   assign rsp_pitch_angle = rsp_pitch_ff;
   assign rsp_yaw_angle   = rsp_yaw_ff;

endmodule

[design/imu_complementary_attitude.sv]
// IMU complementary attitude estimator, top level: configuration registers,
// controller and datapath. Uses imuca_pkg, imuca_ctrl, imuca_dp and the macro header.
//
// An item on the req_ channel is one IMU sample; it is taken when req_valid is
// high and req_stall is low. Each item yields exactly one item on the rsp_
// channel with roll, pitch and yaw in signed Q4.27 radians.
// An item's results are written at the end of its sequence, and no new item is
// taken before that sequence is done. The pace is set by the single shared
// 34x18 multiplier, which computes the twelve products of an item one per cycle unless held by rsp_stall.
// A finished result waits in the output registers while rsp_stall is high; the
// next item runs meanwhile and pauses just before it would overwrite them.
// Synchronous reset clears the bias and angle estimates, drops rsp_valid and
// restores the configuration registers to their defaults. The user must write
// configuration through csr_we, csr_index and csr_wdata only while no item is in
// flight; the block does not enforce this. Unknown indexes are ignored.
`include "imu_complementary_attitude_macros.svh"

module imu_complementary_attitude
   import imuca_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [31:0]            req_sample_time,
   input  logic signed [15:0]     req_gyro_x,
   input  logic signed [15:0]     req_gyro_y,
   input  logic signed [15:0]     req_gyro_z,
   input  logic signed [15:0]     req_accel_x,
   input  logic signed [15:0]     req_accel_y,
   input  logic                   req_pitch_reset,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic signed [31:0]     rsp_roll_angle,
   output logic signed [31:0]     rsp_pitch_angle,
   output logic signed [31:0]     rsp_yaw_angle
);

   cfg_type       cfg_ff;
   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.calib_end_time <= CALIB_END_RST;
         cfg_ff.bias_weight    <= BIAS_WEIGHT_RST;
         cfg_ff.step_time      <= STEP_TIME_RST;
         cfg_ff.blend_weight   <= BLEND_WEIGHT_RST;
         cfg_ff.inv_gravity    <= INV_GRAVITY_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_CALIB_END:    cfg_ff.calib_end_time <= csr_wdata;
            CSR_BIAS_WEIGHT:  cfg_ff.bias_weight    <= csr_wdata[15:0];
            CSR_STEP_TIME:    cfg_ff.step_time      <= csr_wdata[15:0];
            CSR_BLEND_WEIGHT: cfg_ff.blend_weight   <= csr_wdata[15:0];
            CSR_INV_GRAVITY:  cfg_ff.inv_gravity    <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   imuca_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (dp_status),
      .cmd       (dp_cmd)
   );

   imuca_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .cmd             (dp_cmd),
      .status          (dp_status),
      .req_sample_time (req_sample_time),
      .req_gyro_x      (req_gyro_x),
      .req_gyro_y      (req_gyro_y),
      .req_gyro_z      (req_gyro_z),
      .req_accel_x     (req_accel_x),
      .req_accel_y     (req_accel_y),
      .req_pitch_reset (req_pitch_reset),
      .rsp_roll_angle  (rsp_roll_angle),
      .rsp_pitch_angle (rsp_pitch_angle),
      .rsp_yaw_angle   (rsp_yaw_angle)
   );

   `IMUCA_ASSERT_NORST(a_reset_drops_valid, clock, reset |=> !rsp_valid, "rsp_valid set after reset")
   `IMUCA_ASSERT(a_busy_after_accept, clock, reset, req_valid && !req_stall |=> req_stall, "second item taken while one is in flight")
   `IMUCA_ASSERT(a_pitch_then_valid, clock, reset, dp_cmd.wb == WB_PITCH |=> rsp_valid, "last write back not followed by a result")
   `IMUCA_ASSERT(a_bias_only_in_calib, clock, reset, dp_cmd.wb == WB_BIAS_X || dp_cmd.wb == WB_BIAS_Y || dp_cmd.wb == WB_BIAS_Z |-> dp_status.calib, "bias updated outside calibration")

endmodule
